// ===== rtl/cba_pkg.sv =====
package cba_pkg;

  // Build-time defaults
  localparam int unsigned MAX_CHUNKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 32;

  // Port and field widths
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 120;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MAXC_W      = 5;
  localparam int unsigned IDX_OUT_W   = 4;
  localparam int unsigned OFS_W       = 32;
  localparam int unsigned BUF_W       = 16;

  // Register map
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNKS = 1'b1;

  // Reset values of the registers
  localparam logic [OFS_W-1:0]  CHUNK_SIZE_RST = 32'd4096;
  localparam logic [MAXC_W-1:0] MAX_CHUNKS_RST = 5'd16;

  // Request kinds (in_tuser)
  localparam logic REQ_BEGIN_FRAME = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                 accepted;
    logic [IDX_OUT_W-1:0] chunk_index;
    logic [OFS_W-1:0]     src_offset;
    logic                 new_chunk;
    logic [BUF_W-1:0]     job_dest_buffer;
    logic [OFS_W-1:0]     job_dest_offset;
    logic [OFS_W-1:0]     job_size;
  } res_t;

  // Lowest field in the lowest bits, padded to whole bytes
  function automatic logic [OUT_TDATA_W-1:0] pack_res(input res_t r);
    return {2'b00, r.job_size, r.job_dest_offset, r.job_dest_buffer,
            r.new_chunk, r.src_offset, r.chunk_index, r.accepted};
  endfunction

endpackage

// ===== rtl/chunked_bump_allocator_top.sv =====
// Channel  Direction  Bits (lowest first)
// -------  ---------  ----------------------------------------------------------
// in_      slave      tuser: req_type | tdata: size, dest_buffer, dest_offset
// out_     master     tdata: accepted, chunk_index, src_offset, new_chunk,
//                            job_dest_buffer, job_dest_offset, job_size, 2 pad
// cfg_     write      index 0 chunk_size, index 1 max_chunks (wdata[4:0])
//
// One request at a time. Begin frame and rejected sizes go straight to the response
// state; others scan the live chunks in order (one RAM read per chunk visited) and,
// if none fits, try to activate a new chunk. in_ is ready again once the result
// register loads. Reset (rst_n low, synchronous) clears head valid bits, active
// count, FSM and out_tvalid, and reloads both cfg_ registers; capacities are never
// cleared. A stalled out_ side only holds the FSM in its response state; in_ is
// taken again while the last result still waits.
module chunked_bump_allocator_top #(
  parameter int unsigned MAX_CHUNKS = cba_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned SIZE_BITS  = cba_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // req_type
  input  logic                               in_tuser,
  // size [31:0], dest_buffer [47:32], dest_offset [79:48]
  input  logic [cba_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // accepted [0], chunk_index [4:1], src_offset [36:5], new_chunk [37],
  // job_dest_buffer [53:38], job_dest_offset [85:54], job_size [117:86]
  output logic [cba_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wr_en,
  input  logic [cba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import cba_pkg::*;

  localparam int CW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;  // chunk index
  localparam int ACW = $clog2(MAX_CHUNKS + 1);                     // active count
  localparam int LW  = (ACW > MAXC_W) ? ACW : MAXC_W;              // limit compare
  localparam int XW  = (SIZE_BITS > OFS_W) ? SIZE_BITS : OFS_W;    // common size width
  localparam int IXW = (CW > IDX_OUT_W) ? CW : IDX_OUT_W;
  localparam int MW  = 2 * SIZE_BITS;                              // {capacity, head}

  // Configuration
  logic [OFS_W-1:0]  chunk_size_r;
  logic [MAXC_W-1:0] max_chunks_r;

  // Control
  state_t            state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [ACW-1:0]    act_cnt_r, act_cnt_nxt;
  logic [MAX_CHUNKS-1:0] head_vld_r;

  // Request held for the scan
  logic [OFS_W-1:0]  req_size_r;
  logic [BUF_W-1:0]  req_buf_r;
  logic [OFS_W-1:0]  req_doff_r;

  // Result staging and output register
  res_t              res_r, res_nxt;
  res_t              out_res_r;
  logic              out_valid_r;

  // RAM
  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [MW-1:0]     ram_wdata;
  logic [CW-1:0]     ram_raddr;
  logic [MW-1:0]     ram_rdata;

  // Datapath
  logic              in_fire;
  logic              in_begin;
  logic              in_bad;
  logic [XW-1:0]     size_in_x;
  logic [XW-1:0]     req_size_x;
  logic [SIZE_BITS-1:0] size_sb;
  logic [SIZE_BITS-1:0] cap_rd;
  logic [SIZE_BITS-1:0] head_rd;
  logic [SIZE_BITS-1:0] head_sum;
  logic              fits;
  logic [ACW-1:0]    idx_inc;
  logic              more;
  logic              can_act;
  logic [XW-1:0]     cs_x;
  logic [XW-1:0]     cap_max;
  logic [SIZE_BITS-1:0] cap_new;
  logic [XW-1:0]     src_x;
  logic [IXW-1:0]    idx_x;
  logic [IXW-1:0]    new_x;
  logic              resp_go;
  logic              vld_set;

  cba_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_CHUNKS),
    .AW    (CW)
  ) u_chunk_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_fire   = in_tvalid && in_tready;
  assign in_begin  = (in_tuser == REQ_BEGIN_FRAME);
  assign size_in_x = XW'(in_tdata[31:0]);
  // zero size, or more bits than a head can hold
  assign in_bad    = (in_tdata[31:0] == '0) || ((size_in_x >> SIZE_BITS) != '0);

  assign req_size_x = XW'(req_size_r);
  assign size_sb    = req_size_x[SIZE_BITS-1:0];

  // a head whose valid bit is clear reads as zero (reset / frame begin)
  assign cap_rd   = ram_rdata[MW-1:SIZE_BITS];
  assign head_rd  = head_vld_r[idx_r] ? ram_rdata[SIZE_BITS-1:0] : '0;
  assign fits     = (head_rd <= cap_rd) && ((cap_rd - head_rd) >= size_sb);
  assign head_sum = head_rd + size_sb;

  assign idx_inc = ACW'(idx_r) + ACW'(1);
  assign more    = (idx_inc < act_cnt_r);
  assign can_act = (LW'(act_cnt_r) < LW'(max_chunks_r)) &&
                   (act_cnt_r < ACW'(MAX_CHUNKS));

  // new capacity: max(chunk_size, size), saturated to the head width
  assign cs_x    = XW'(chunk_size_r);
  assign cap_max = (cs_x > req_size_x) ? cs_x : req_size_x;
  assign cap_new = ((cap_max >> SIZE_BITS) != '0) ? '1 : cap_max[SIZE_BITS-1:0];

  assign src_x = XW'(head_rd);
  assign idx_x = IXW'(idx_r);
  assign new_x = IXW'(act_cnt_r[CW-1:0]);

  assign resp_go = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_begin || in_bad) begin
            state_nxt = ST_RESP;
          end else if (act_cnt_r == '0) begin
            state_nxt = ST_ACT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fits) begin
          state_nxt = ST_RESP;
        end else if (!more) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (resp_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the FSM
  always_comb begin
    in_tready   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {cap_rd, head_sum};
    ram_raddr   = '0;
    vld_set     = 1'b0;
    idx_nxt     = idx_r;
    act_cnt_nxt = act_cnt_r;
    res_nxt     = res_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_raddr = '0;
        idx_nxt   = '0;
        res_nxt   = '0;
        res_nxt.accepted = in_begin;
      end
      ST_SCAN: begin
        ram_raddr = idx_inc[CW-1:0];
        if (fits) begin
          ram_we                  = 1'b1;
          vld_set                 = 1'b1;
          res_nxt.accepted        = 1'b1;
          res_nxt.chunk_index     = idx_x[IDX_OUT_W-1:0];
          res_nxt.src_offset      = src_x[OFS_W-1:0];
          res_nxt.new_chunk       = 1'b0;
          res_nxt.job_dest_buffer = req_buf_r;
          res_nxt.job_dest_offset = req_doff_r;
          res_nxt.job_size        = req_size_r;
        end else if (more) begin
          idx_nxt = idx_inc[CW-1:0];
        end
      end
      ST_ACT: begin
        ram_waddr = act_cnt_r[CW-1:0];
        ram_wdata = {cap_new, size_sb};
        res_nxt   = '0;
        if (can_act) begin
          ram_we                  = 1'b1;
          vld_set                 = 1'b1;
          act_cnt_nxt             = act_cnt_r + ACW'(1);
          res_nxt.accepted        = 1'b1;
          res_nxt.chunk_index     = new_x[IDX_OUT_W-1:0];
          res_nxt.new_chunk       = 1'b1;
          res_nxt.job_dest_buffer = req_buf_r;
          res_nxt.job_dest_offset = req_doff_r;
          res_nxt.job_size        = req_size_r;
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      act_cnt_r    <= '0;
      head_vld_r   <= '0;
      out_valid_r  <= 1'b0;
      chunk_size_r <= CHUNK_SIZE_RST;
      max_chunks_r <= MAX_CHUNKS_RST;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      act_cnt_r <= act_cnt_nxt;

      // frame begin drops every head back to zero
      if (in_fire && in_begin) begin
        head_vld_r <= '0;
      end else if (vld_set) begin
        head_vld_r[ram_waddr] <= 1'b1;
      end

      if (state_r == ST_RESP && resp_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_CHUNK_SIZE: chunk_size_r <= cfg_wdata;
          REG_MAX_CHUNKS: max_chunks_r <= cfg_wdata[MAXC_W-1:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_fire) begin
      req_size_r <= in_tdata[31:0];
      req_buf_r  <= in_tdata[47:32];
      req_doff_r <= in_tdata[79:48];
    end
    if (state_r == ST_RESP && resp_go) begin
      out_res_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pack_res(out_res_r);

endmodule

// ===== rtl/cba_ram.sv =====
module cba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== test/tb_chunked_bump_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_chunked_bump_allocator_top;
  import cba_pkg::*;

  // Allocation is the other request kind on in_tuser
  localparam logic        REQ_ALLOCATE   = ~REQ_BEGIN_FRAME;
  localparam int unsigned POOL_DEPTH     = MAX_CHUNKS_DEF;
  // Cycles without any transfer before the run is abandoned. Worst honest case is
  // a long receiver stall at 88 % plus a full 16-chunk scan, well under this.
  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned PHASE_COUNT    = 6;
  // Longest path is a scan over all 16 live chunks ending in an activation attempt
  localparam int unsigned TAIL_CYCLES    = 24;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  // One step of the directed sequence. For ROW_CFG, sel is the register index and
  // value the data written; for ROW_REQ, sel is the request kind and value the size.
  typedef struct {
    row_kind_t   kind;
    logic        sel;
    logic [31:0] value;
    logic [15:0] buf_id;
    logic [31:0] ofs;
    bit          typed;   // want holds a hand-written result
    res_t        want;
  } row_t;

  localparam res_t REFUSED = '0;
  localparam res_t BEGUN   = '{1'b1, 4'd0, 32'd0, 1'b0, 16'd0, 32'd0, 32'd0};

  // Directed walk, starting from the reset settings (chunk_size 4096, 16 chunks)
  row_t plan [22] = '{
    // very first request lands at the start of a fresh chunk 0
    '{ROW_REQ, REQ_ALLOCATE, 32'd100, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 4'd0, 32'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd100}},
    // zero size is refused outright
    '{ROW_REQ, REQ_ALLOCATE, 32'd0, 16'h1234, 32'h0000_5678, 1'b1, REFUSED},
    // fills chunk 0 to the last byte
    '{ROW_REQ, REQ_ALLOCATE, 32'd3996, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd1, 16'h0001, 32'h0000_0001, 1'b0, '0},
    // frame begin ignores whatever rides along in tdata
    '{ROW_REQ, REQ_BEGIN_FRAME, 32'hDEAD_BEEF, 16'hABCD, 32'h1234_5678, 1'b1, BEGUN},
    '{ROW_REQ, REQ_ALLOCATE, 32'd4096, 16'h00FF, 32'h0000_FF00, 1'b0, '0},
    // one byte over chunk_size: new chunk sized to the request
    '{ROW_REQ, REQ_ALLOCATE, 32'd4097, 16'hFF00, 32'h00FF_0000, 1'b0, '0},
    // pool closed while three chunks are live
    '{ROW_CFG, REG_MAX_CHUNKS, 32'd0, 16'd0, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'hFFFF_FFFF, 16'h5555, 32'hAAAA_AAAA, 1'b1, REFUSED},
    // live chunks still take what fits
    '{ROW_REQ, REQ_ALLOCATE, 32'd10, 16'hAAAA, 32'h5555_5555, 1'b0, '0},
    // limit equal to the live count: no room anywhere
    '{ROW_CFG, REG_MAX_CHUNKS, 32'd3, 16'd0, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd5000, 16'h0F0F, 32'hF0F0_F0F0, 1'b1, REFUSED},
    // default capacity of zero, limit above the pool (saturates)
    '{ROW_CFG, REG_CHUNK_SIZE, 32'd0, 16'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_MAX_CHUNKS, 32'd31, 16'd0, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd5000, 16'h3C3C, 32'h0000_0400, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd1, 16'hC3C3, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, REG_CHUNK_SIZE, 32'd128, 16'd0, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_BEGIN_FRAME, 32'd0, 16'd0, 32'd0, 1'b1, BEGUN},
    '{ROW_REQ, REQ_ALLOCATE, 32'd8192, 16'h0002, 32'h0000_2000, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd4096, 16'h0003, 32'h0000_3000, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd1, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_REQ, REQ_ALLOCATE, 32'd128, 16'hAAAA, 32'h5555_5555, 1'b0, '0}
  };

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  // req_type
  logic                   in_tuser  = 1'b0;
  // size [31:0], dest_buffer [47:32], dest_offset [79:48]
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // accepted, chunk_index, src_offset, new_chunk, job_dest_buffer,
  // job_dest_offset, job_size, 2 pad bits
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  chunked_bump_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow of the allocator: per-chunk head and capacity, live count, registers
  logic [31:0]  pool_head [POOL_DEPTH];
  logic [31:0]  pool_cap  [POOL_DEPTH];
  int unsigned  pool_live   = 0;
  logic [31:0]  chunk_bytes = CHUNK_SIZE_RST;
  logic [4:0]   chunk_limit = MAX_CHUNKS_RST;

  res_t         job_q [$];       // results still owed by the block, oldest first
  int unsigned  items_sent      = 0;
  int unsigned  results_matched = 0;
  int unsigned  errors          = 0;
  int unsigned  n_begin         = 0;
  int unsigned  n_refused       = 0;
  int unsigned  n_fresh         = 0;
  int unsigned  n_writes        = 0;
  int unsigned  snd_idle        = 21;  // percent of cycles the sender holds back
  int unsigned  rcv_idle        = 88;  // percent of cycles out_tready is low
  int unsigned  quiet_cycles    = 0;

  // First-fit placement over the live chunks, else activate the next one
  function automatic res_t place_request(logic kind, logic [31:0] nbytes,
                                         logic [15:0] buf_id, logic [31:0] ofs);
    res_t        r;
    int unsigned ceiling;
    r = '0;
    if (kind == REQ_BEGIN_FRAME) begin
      foreach (pool_head[i]) pool_head[i] = '0;
      r.accepted = 1'b1;
      return r;
    end
    if (nbytes == '0) return r;
    for (int unsigned i = 0; i < pool_live; i++) begin
      if (pool_head[i] <= pool_cap[i] && pool_cap[i] - pool_head[i] >= nbytes) begin
        r = '{1'b1, 4'(i), pool_head[i], 1'b0, buf_id, ofs, nbytes};
        pool_head[i] = pool_head[i] + nbytes;
        return r;
      end
    end
    ceiling = (chunk_limit > POOL_DEPTH) ? POOL_DEPTH : chunk_limit;
    if (pool_live < ceiling) begin
      pool_cap[pool_live]  = (chunk_bytes > nbytes) ? chunk_bytes : nbytes;
      pool_head[pool_live] = nbytes;
      r = '{1'b1, 4'(pool_live), 32'd0, 1'b1, buf_id, ofs, nbytes};
      pool_live++;
    end
    return r;
  endfunction

  // Mostly sizes well below a chunk so chunks fill up and spill over; a few zeros
  // and a few across the whole 32-bit range
  function automatic logic [31:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3)  return '0;
    if (roll < 6)  return $urandom;
    if (roll < 60) return $urandom_range(256, 1);
    if (roll < 85) return $urandom_range(4096, 1);
    return $urandom_range(65536, 1);
  endfunction

  // Call it in step with clk; it returns once the in_ transfer has been taken
  task automatic send_req(logic kind, logic [31:0] nbytes, logic [15:0] buf_id,
                          logic [31:0] ofs, bit typed, res_t typed_want);
    res_t want;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ofs, buf_id, nbytes};
    do @(posedge clk); while (!in_tready);
    want = place_request(kind, nbytes, buf_id, ofs);
    if (typed) want = typed_want;
    job_q.push_back(want);
    items_sent++;
    if (kind == REQ_BEGIN_FRAME) n_begin++;
    else if (!want.accepted) n_refused++;
    if (want.new_chunk) n_fresh++;
  endtask

  // Stop offering requests and wait until every owed result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_matched != items_sent) @(posedge clk);
  endtask

  // Lowers cfg_wr_en before returning, so back-to-back writes never drive it twice in a step
  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_CHUNK_SIZE) chunk_bytes = value;
    else chunk_limit = value[MAXC_W-1:0];
    n_writes++;
    @(posedge clk);
  endtask

  task automatic diff_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns  %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: check each out_ transfer against the oldest owed job, then
  // draw the next out_tready. Values read here are those before the edge.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted        = out_tdata[0];
      got.chunk_index     = out_tdata[4:1];
      got.src_offset      = out_tdata[36:5];
      got.new_chunk       = out_tdata[37];
      got.job_dest_buffer = out_tdata[53:38];
      got.job_dest_offset = out_tdata[85:54];
      got.job_size        = out_tdata[117:86];
      if (job_q.size() == 0) begin
        $display("%0t ns  result with nothing owed: expected none, got tdata 0x%0h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = job_q.pop_front();
        diff_field("accepted",        want.accepted,        got.accepted);
        diff_field("chunk_index",     want.chunk_index,     got.chunk_index);
        diff_field("src_offset",      want.src_offset,      got.src_offset);
        diff_field("new_chunk",       want.new_chunk,       got.new_chunk);
        diff_field("job_dest_buffer", want.job_dest_buffer, got.job_dest_buffer);
        diff_field("job_dest_offset", want.job_dest_offset, got.job_dest_offset);
        diff_field("job_size",        want.job_size,        got.job_size);
        results_matched <= results_matched + 1;
      end
    end
    out_tready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);
  end

  // Watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t ns  no transfer for %0d cycles, %0d results still owed",
               $time, STALL_LIMIT, job_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic        kind;
    logic [31:0] phase_bytes   [PHASE_COUNT];
    logic [4:0]  phase_ceiling [PHASE_COUNT];

    foreach (pool_head[i]) begin
      pool_head[i] = '0;
      pool_cap[i]  = '0;
    end
    // chunk_size: floor, not a power of two, mid random, zero, wider random, full scale.
    // max_chunks: one (below the live count), middling, larger, saturating, full, over the pool.
    phase_bytes   = '{32'd128, 32'd300, 32'($urandom_range(8192, 128)), 32'd0,
                      32'($urandom_range(65535, 128)), 32'hFFFF_FFFF};
    phase_ceiling = '{5'd1, 5'd6, 5'd12, 5'd31, 5'd16, 5'd17};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk: sender 21 %, receiver 88 %
    foreach (plan[n]) begin
      if (plan[n].kind == ROW_CFG) begin
        settle();
        cfg_write(plan[n].sel, plan[n].value);
      end else begin
        send_req(plan[n].sel, plan[n].value, plan[n].buf_id, plan[n].ofs,
                 plan[n].typed, plan[n].want);
      end
    end

    // Random phases: two settings per idling pattern. Bursts of allocations run
    // between occasional frame begins, so heads climb and chunks spill over.
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      cfg_write(REG_CHUNK_SIZE, phase_bytes[phase]);
      cfg_write(REG_MAX_CHUNKS, 32'(phase_ceiling[phase]));
      snd_idle  = (phase < 2) ? 21 : (phase < 4) ? 88 : 0;
      rcv_idle <= (phase < 2) ? 88 : (phase < 4) ? 21 : 0;
      repeat (PHASE_ITEMS) begin
        kind = ($urandom_range(99) < 4) ? REQ_BEGIN_FRAME : REQ_ALLOCATE;
        send_req(kind, pick_size(), 16'($urandom), $urandom, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (job_q.size() != 0) begin
      $display("%0t ns  results left over: expected 0, got %0d", $time, job_q.size());
      errors++;
    end

    $display("%0d requests: %0d frame begins, %0d refused, %0d chunk activations",
             items_sent, n_begin, n_refused, n_fresh);
    $display("%0d register writes, %0d field mismatches", n_writes, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cba_pkg.sv
rtl/cba_ram.sv
rtl/chunked_bump_allocator_top.sv
test/tb_chunked_bump_allocator_top.sv
